### rtl/u8cp_pkg.sv
// Shared types, constants and codes for the UTF-8 / OEM code page codec.
`timescale 1ns / 1ps

package u8cp_pkg;

   // Table geometry
   localparam int PAGES          = 4;
   localparam int PAGE_ENTRIES   = 128;
   localparam int ENTRY_BITS     = $clog2(PAGE_ENTRIES);
   localparam int PAGE_BITS      = (PAGES > 1) ? $clog2(PAGES) : 1;
   localparam int WORD_ADDR_BITS = PAGE_BITS + ENTRY_BITS;

   typedef logic [PAGE_BITS-1:0]      page_idx_type;
   typedef logic [ENTRY_BITS-1:0]     entry_idx_type;
   typedef logic [WORD_ADDR_BITS-1:0] word_addr_type;

   // Character constants
   localparam logic [7:0]  BAD_CHAR       = 8'h7F;
   localparam logic [15:0] REPLACEMENT    = 16'hFFFD;
   localparam logic [20:0] CODE_POINT_MAX = 21'h10FFFF;
   localparam logic [20:0] SURROGATE_LO   = 21'h00D800;
   localparam logic [20:0] SURROGATE_HI   = 21'h00DFFF;
   localparam logic [20:0] MIN_TWO_BYTE   = 21'h000080;
   localparam logic [20:0] MIN_THREE_BYTE = 21'h000800;
   localparam logic [20:0] MIN_FOUR_BYTE  = 21'h010000;

   // Register indexes on the CSR port
   localparam logic CSR_CODE_PAGE    = 1'b0;
   localparam logic CSR_PAGES_IN_USE = 1'b1;

   typedef enum logic [1:0] {
      OP_LOAD_ID   = 2'd0,
      OP_LOAD_WORD = 2'd1,
      OP_DECODE    = 2'd2,
      OP_ENCODE    = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_READ,
      ST_SCAN,
      ST_EMIT
   } state_type;

   typedef struct packed {
      op_type      operation;
      logic [1:0]  slot;
      logic [6:0]  entry;
      logic [15:0] value;
      logic [7:0]  byte_in;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last;
   } rsp_type;

   // Controller to datapath
   typedef struct packed {
      logic latch_item;
      logic write_id;
      logic write_word;
      logic decode_step;
      logic encode_direct;
      logic encode_word;
      logic scan_start;
      logic scan_run;
      logic scan_finish;
      logic emit;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      op_type op;
      logic   dec_scan;
      logic   dec_empty;
      logic   enc_direct;
      logic   scan_end;
      logic   out_free;
      logic   emit_last;
   } status_type;

endpackage

### rtl/u8cp_dp.sv
// Datapath: CSRs, page tables, UTF-8 decode state, result buffer and output register.
`timescale 1ns / 1ps

module u8cp_dp (
   input  logic                 clock,
   input  logic                 reset,
   input  u8cp_pkg::cmd_type    cmd,
   output u8cp_pkg::status_type status,
   input  u8cp_pkg::req_type    req_data,
   input  logic                 rsp_stall,
   output logic                 rsp_valid,
   output u8cp_pkg::rsp_type    rsp_data,
   input  logic                 csr_write_en,
   input  logic                 csr_index,
   input  logic [15:0]          csr_data
);

   // Configuration
   logic [15:0] code_page_ff;
   logic [2:0]  pages_in_use_ff;

   // Tables
   logic [15:0] page_ids_ff [u8cp_pkg::PAGES];
   logic [15:0] words_mem [u8cp_pkg::PAGES*u8cp_pkg::PAGE_ENTRIES];
   logic [15:0] rd_data_ff;
   u8cp_pkg::word_addr_type rd_addr;

   // Item and decode state
   u8cp_pkg::req_type item_ff;
   logic [20:0] acc_ff, acc_in;
   logic [1:0]  bytes_left_ff, bytes_left_in;
   logic [1:0]  seq_length_ff, seq_length_in;
   logic [15:0] cp_ff;

   // Scan pipeline
   u8cp_pkg::entry_idx_type scan_idx_ff;
   u8cp_pkg::entry_idx_type tag_ff;
   logic                    tag_valid_ff;
   logic                    scan_hit;

   // Result buffer and output register
   logic [7:0] res_ff [3];
   logic [1:0] res_cnt_ff;
   logic [1:0] res_pos_ff;
   logic       rsp_valid_ff;
   u8cp_pkg::rsp_type rsp_data_ff;

   // Page search
   logic                   page_hit;
   u8cp_pkg::page_idx_type page_idx;

   // Decode step
   logic [7:0]  b;
   logic [20:0] acc_shift;
   logic [20:0] min_cp;
   logic        lead_emit;
   logic [7:0]  lead_byte;
   logic [20:0] lead_acc;
   logic [1:0]  lead_bl;
   logic [1:0]  lead_seq;
   logic [1:0]  dec_cnt;
   logic [7:0]  dec_r0, dec_r1;
   logic        dec_scan;

   // Encode
   logic [15:0] enc_u;
   logic [1:0]  enc_cnt;
   logic [7:0]  enc_b0, enc_b1, enc_b2;

   logic [2:0]  slot_ok_cmp;

   // Find the first searched slot whose id matches code_page
   always_comb begin
      page_hit = 1'b0;
      page_idx = '0;
      for (int i = 0; i < u8cp_pkg::PAGES; i++) begin
         if (!page_hit && (i < int'(pages_in_use_ff)) && (page_ids_ff[i] == code_page_ff)) begin
            page_hit = 1'b1;
            page_idx = u8cp_pkg::page_idx_type'(i);
         end
      end
   end

   assign slot_ok_cmp = {1'b0, item_ff.slot};

   // CSR writes
   always_ff @(posedge clock) begin
      if (reset) begin
         code_page_ff    <= '0;
         pages_in_use_ff <= '0;
      end else if (csr_write_en) begin
         unique case (csr_index)
            u8cp_pkg::CSR_CODE_PAGE:    code_page_ff    <= csr_data;
            u8cp_pkg::CSR_PAGES_IN_USE: pages_in_use_ff <= csr_data[2:0];
            default: ;
         endcase
      end
   end

   // Latch the accepted word
   always_ff @(posedge clock) begin
      if (cmd.latch_item) begin
         item_ff <= req_data;
      end
   end

   // Page id writes
   always_ff @(posedge clock) begin
      if (cmd.write_id && (int'(slot_ok_cmp) < u8cp_pkg::PAGES)) begin
         page_ids_ff[u8cp_pkg::page_idx_type'(item_ff.slot)] <= item_ff.value;
      end
   end

   // Page word memory: one write port, one registered read port
   always_comb begin
      if (cmd.scan_run) begin
         rd_addr = {page_idx, scan_idx_ff};
      end else begin
         rd_addr = {page_idx, item_ff.byte_in[6:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.write_word && (int'(slot_ok_cmp) < u8cp_pkg::PAGES)) begin
         words_mem[{u8cp_pkg::page_idx_type'(item_ff.slot), item_ff.entry}] <= item_ff.value;
      end
      rd_data_ff <= words_mem[rd_addr];
   end

   // Lead byte classification
   assign b         = item_ff.byte_in;
   assign acc_shift = {acc_ff[14:0], b[5:0]};

   always_comb begin
      lead_emit = 1'b0;
      lead_byte = b;
      lead_acc  = acc_ff;
      lead_bl   = 2'd0;
      lead_seq  = seq_length_ff;
      if (b[7] == 1'b0) begin
         lead_emit = 1'b1;
      end else if (b[7:5] == 3'b110) begin
         lead_acc = {16'd0, b[4:0]};
         lead_bl  = 2'd1;
         lead_seq = 2'd1;
      end else if (b[7:4] == 4'b1110) begin
         lead_acc = {17'd0, b[3:0]};
         lead_bl  = 2'd2;
         lead_seq = 2'd2;
      end else if (b[7:3] == 5'b11110) begin
         lead_acc = {18'd0, b[2:0]};
         lead_bl  = 2'd3;
         lead_seq = 2'd3;
      end else begin
         lead_emit = 1'b1;
         lead_byte = u8cp_pkg::BAD_CHAR;
      end
   end

   always_comb begin
      case (seq_length_ff)
         2'd1:    min_cp = u8cp_pkg::MIN_TWO_BYTE;
         2'd2:    min_cp = u8cp_pkg::MIN_THREE_BYTE;
         2'd3:    min_cp = u8cp_pkg::MIN_FOUR_BYTE;
         default: min_cp = '0;
      endcase
   end

   // One decode step: next sequence state and up to two immediate results
   always_comb begin
      acc_in        = acc_ff;
      bytes_left_in = bytes_left_ff;
      seq_length_in = seq_length_ff;
      dec_cnt       = 2'd0;
      dec_r0        = u8cp_pkg::BAD_CHAR;
      dec_r1        = u8cp_pkg::BAD_CHAR;
      dec_scan      = 1'b0;
      if ((bytes_left_ff != 2'd0) && (b[7:6] == 2'b10)) begin
         // continuation: shift in six bits, finish on the last one
         acc_in        = acc_shift;
         bytes_left_in = bytes_left_ff - 2'd1;
         if (bytes_left_ff == 2'd1) begin
            dec_cnt = 2'd1;
            if ((acc_shift < min_cp) || (acc_shift > u8cp_pkg::CODE_POINT_MAX)) begin
               dec_r0 = u8cp_pkg::BAD_CHAR;
            end else if ((acc_shift >= u8cp_pkg::SURROGATE_LO) &&
                         (acc_shift <= u8cp_pkg::SURROGATE_HI)) begin
               dec_r0 = u8cp_pkg::BAD_CHAR;
            end else if (acc_shift < u8cp_pkg::MIN_TWO_BYTE) begin
               dec_r0 = acc_shift[7:0];
            end else if ((acc_shift >= u8cp_pkg::MIN_FOUR_BYTE) || !page_hit) begin
               dec_r0 = u8cp_pkg::BAD_CHAR;
            end else begin
               dec_cnt  = 2'd0;
               dec_scan = 1'b1;
            end
         end
      end else if (bytes_left_ff != 2'd0) begin
         // broken sequence: flag it, then take the byte as a lead
         dec_r0 = u8cp_pkg::BAD_CHAR;
         if (lead_emit) begin
            dec_r1        = lead_byte;
            dec_cnt       = 2'd2;
            bytes_left_in = 2'd0;
         end else begin
            dec_cnt       = 2'd1;
            acc_in        = lead_acc;
            bytes_left_in = lead_bl;
            seq_length_in = lead_seq;
         end
      end else begin
         if (lead_emit) begin
            dec_r0  = lead_byte;
            dec_cnt = 2'd1;
         end else begin
            acc_in        = lead_acc;
            bytes_left_in = lead_bl;
            seq_length_in = lead_seq;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff        <= '0;
         bytes_left_ff <= '0;
         seq_length_ff <= '0;
      end else if (cmd.decode_step) begin
         acc_ff        <= acc_in;
         bytes_left_ff <= bytes_left_in;
         seq_length_ff <= seq_length_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.decode_step && dec_scan) begin
         cp_ff <= acc_shift[15:0];
      end
   end

   // Reverse lookup: one page word a cycle, compare in the cycle after the read
   assign scan_hit = tag_valid_ff && (rd_data_ff == cp_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_idx_ff  <= '0;
         tag_valid_ff <= 1'b0;
      end else if (cmd.scan_start) begin
         scan_idx_ff  <= '0;
         tag_valid_ff <= 1'b0;
      end else if (cmd.scan_run) begin
         scan_idx_ff  <= scan_idx_ff + 1'b1;
         tag_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_run) begin
         tag_ff <= scan_idx_ff;
      end
   end

   // Encode: pick the code unit and split it into UTF-8 bytes
   always_comb begin
      if (cmd.encode_direct) begin
         enc_u = (b[7] == 1'b0) ? {8'd0, b} : u8cp_pkg::REPLACEMENT;
      end else begin
         enc_u = (rd_data_ff == 16'd0) ? u8cp_pkg::REPLACEMENT : rd_data_ff;
      end
      enc_b1 = {2'b10, enc_u[5:0]};
      enc_b2 = {2'b10, enc_u[5:0]};
      if (enc_u < 16'h0080) begin
         enc_b0  = enc_u[7:0];
         enc_cnt = 2'd1;
      end else if (enc_u < 16'h0800) begin
         enc_b0  = {3'b110, enc_u[10:6]};
         enc_cnt = 2'd2;
      end else begin
         enc_b0  = {4'b1110, enc_u[15:12]};
         enc_b1  = {2'b10, enc_u[11:6]};
         enc_cnt = 2'd3;
      end
   end

   // Fill the result buffer and advance through it
   always_ff @(posedge clock) begin
      if (reset) begin
         res_cnt_ff <= '0;
         res_pos_ff <= '0;
      end else if (cmd.decode_step) begin
         res_ff[0]  <= dec_r0;
         res_ff[1]  <= dec_r1;
         res_cnt_ff <= dec_cnt;
         res_pos_ff <= '0;
      end else if (cmd.scan_finish) begin
         res_ff[0]  <= scan_hit ? {1'b1, tag_ff} : u8cp_pkg::BAD_CHAR;
         res_cnt_ff <= 2'd1;
         res_pos_ff <= '0;
      end else if (cmd.encode_direct || cmd.encode_word) begin
         res_ff[0]  <= enc_b0;
         res_ff[1]  <= enc_b1;
         res_ff[2]  <= enc_b2;
         res_cnt_ff <= enc_cnt;
         res_pos_ff <= '0;
      end else if (cmd.emit) begin
         res_pos_ff <= res_pos_ff + 2'd1;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_data_ff.out_byte <= res_ff[res_pos_ff];
         rsp_data_ff.last     <= status.emit_last;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Status to the controller
   assign status.op         = item_ff.operation;
   assign status.dec_scan   = dec_scan;
   assign status.dec_empty  = (dec_cnt == 2'd0);
   assign status.enc_direct = (b[7] == 1'b0) || !page_hit;
   assign status.scan_end   = tag_valid_ff && (scan_hit || (tag_ff == '1));
   assign status.out_free   = !rsp_valid_ff || !rsp_stall;
   assign status.emit_last  = (res_pos_ff == (res_cnt_ff - 2'd1));

   a_seq_covers_pending: assert property (@(posedge clock) disable iff (reset)
      bytes_left_ff <= seq_length_ff)
      else $error("pending byte count exceeds sequence length");

   a_emit_in_buffer: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (res_cnt_ff != 2'd0) && (res_pos_ff < res_cnt_ff))
      else $error("emit outside the filled result buffer");

   a_finish_after_compare: assert property (@(posedge clock) disable iff (reset)
      cmd.scan_finish |-> tag_valid_ff)
      else $error("lookup finished before any page word was compared");

endmodule

### rtl/u8cp_ctrl.sv
// Controller: sequences loads, decode, encode, page word lookup and result delivery.
`timescale 1ns / 1ps

module u8cp_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  u8cp_pkg::status_type status,
   output u8cp_pkg::cmd_type    cmd
);

   u8cp_pkg::state_type state_ff, state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= u8cp_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         u8cp_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.latch_item = 1'b1;
               state_in       = u8cp_pkg::ST_EXEC;
            end
         end
         u8cp_pkg::ST_EXEC: begin
            unique case (status.op)
               u8cp_pkg::OP_LOAD_ID: begin
                  cmd.write_id = 1'b1;
                  state_in     = u8cp_pkg::ST_IDLE;
               end
               u8cp_pkg::OP_LOAD_WORD: begin
                  cmd.write_word = 1'b1;
                  state_in       = u8cp_pkg::ST_IDLE;
               end
               u8cp_pkg::OP_DECODE: begin
                  cmd.decode_step = 1'b1;
                  if (status.dec_scan) begin
                     cmd.scan_start = 1'b1;
                     state_in       = u8cp_pkg::ST_SCAN;
                  end else if (status.dec_empty) begin
                     state_in = u8cp_pkg::ST_IDLE;
                  end else begin
                     state_in = u8cp_pkg::ST_EMIT;
                  end
               end
               u8cp_pkg::OP_ENCODE: begin
                  if (status.enc_direct) begin
                     cmd.encode_direct = 1'b1;
                     state_in          = u8cp_pkg::ST_EMIT;
                  end else begin
                     state_in = u8cp_pkg::ST_READ;
                  end
               end
               default: state_in = u8cp_pkg::ST_IDLE;
            endcase
         end
         u8cp_pkg::ST_READ: begin
            cmd.encode_word = 1'b1;
            state_in        = u8cp_pkg::ST_EMIT;
         end
         u8cp_pkg::ST_SCAN: begin
            cmd.scan_run = 1'b1;
            if (status.scan_end) begin
               cmd.scan_finish = 1'b1;
               state_in        = u8cp_pkg::ST_EMIT;
            end
         end
         u8cp_pkg::ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               if (status.emit_last) begin
                  state_in = u8cp_pkg::ST_IDLE;
               end
            end
         end
         default: state_in = u8cp_pkg::ST_IDLE;
      endcase
   end

   a_scan_exits_to_emit: assert property (@(posedge clock) disable iff (reset)
      state_ff == u8cp_pkg::ST_SCAN |=>
         (state_ff == u8cp_pkg::ST_SCAN) || (state_ff == u8cp_pkg::ST_EMIT))
      else $error("lookup left without delivering a result");

   a_read_then_emit: assert property (@(posedge clock) disable iff (reset)
      state_ff == u8cp_pkg::ST_READ |=> state_ff == u8cp_pkg::ST_EMIT)
      else $error("page word read not followed by delivery");

   a_exec_after_accept: assert property (@(posedge clock) disable iff (reset)
      state_ff == u8cp_pkg::ST_EXEC |-> $past(state_ff) == u8cp_pkg::ST_IDLE)
      else $error("execution entered without an accepted word");

endmodule

### rtl/utf8_codepage_codec.sv
// Top level: UTF-8 / OEM code page codec, controller plus datapath.
// A load writes its table in the cycle after accept. A decode or direct encode result
// passes through EXEC and EMIT to the output register, an encode through a page word
// through EXEC, READ and EMIT, and a decoded non-ASCII character, scanning its page one
// word per cycle, through EXEC, SCAN and EMIT. One word at a time: the next is taken
// in IDLE, after the last result enters the output register or after a word with no result.
// Synchronous reset clears the CSRs and decode sequence; page tables are not cleared.
`timescale 1ns / 1ps

module utf8_codepage_codec (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  u8cp_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output u8cp_pkg::rsp_type rsp_data,
   input  logic              csr_write_en,
   input  logic              csr_index,
   input  logic [15:0]       csr_data
);

   u8cp_pkg::cmd_type    cmd;
   u8cp_pkg::status_type status;

   u8cp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   u8cp_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .req_data     (req_data),
      .rsp_stall    (rsp_stall),
      .rsp_valid    (rsp_valid),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data)
   );

endmodule
